/* src/vkt_pkg.sv */
// vkt_pkg: sizes, operation codes and status codes of the versioned key table
// used by versioned_key_table; depends on nothing else
package vkt_pkg;

  localparam int unsigned TABLE_DEPTH  = 32;
  localparam int unsigned PAYLOAD_BITS = 64;
  localparam int unsigned RESULT_CAP   = 32;

  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned REL_W     = 16;
  localparam int unsigned PAY_PORT_W = 64;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned COUNT_W   = 6;

  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EMIT_W = $clog2(RESULT_CAP + 1);

  localparam logic [REL_W-1:0] REL_MAX = {REL_W{1'b1}};

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT  = 2'd0,
    ACT_DEL_ONE = 2'd1,
    ACT_DEL_ALL = 2'd2,
    ACT_SEARCH  = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NO_MATCH  = 3'd4
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic [REL_W-1:0]        rel;
    logic [PAYLOAD_BITS-1:0] pay;
  } slot_t;

endpackage

/* src/versioned_key_table.sv */
// versioned_key_table: keyed table holding several versions per key, one shared
// slot compare unit swept over the slot memory; depends on vkt_pkg
//
//   channel   handshake                 fields
//   request   start / busy              action, key, release_sel, match_any, payload
//   result    result_valid_o (1 cycle)  status, out_key, out_release, out_payload,
//                                       entry_count, key_count, last
//
// every request sweeps all slots through one compare unit, one slot per cycle:
// insert and delete make one pass; a search makes one pass per reported match plus one
// a result strobes the cycle after the pass that completes it; busy is high meanwhile
// reset clears the valid bits and both counts at once, no clearing pass is needed
// results cannot be stalled: each strobe is taken in its own cycle
module versioned_key_table (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [vkt_pkg::ACTION_W-1:0]      action_i,
  input  logic signed [vkt_pkg::KEY_W-1:0]  key_i,
  input  logic [vkt_pkg::REL_W-1:0]         release_sel_i,
  input  logic                              match_any_i,
  input  logic [vkt_pkg::PAY_PORT_W-1:0]    payload_i,
  output logic                              result_valid_o,
  output logic [vkt_pkg::STATUS_W-1:0]      status_o,
  output logic signed [vkt_pkg::KEY_W-1:0]  out_key_o,
  output logic [vkt_pkg::REL_W-1:0]         out_release_o,
  output logic [vkt_pkg::PAY_PORT_W-1:0]    out_payload_o,
  output logic [vkt_pkg::COUNT_W-1:0]       entry_count_o,
  output logic [vkt_pkg::COUNT_W-1:0]       key_count_o,
  output logic                              last_o
);
  import vkt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_q, state_d;

  // request
  action_e                 act_q, act_d;
  logic [KEY_W-1:0]        key_q, key_d;
  logic [REL_W-1:0]        sel_q, sel_d;
  logic                    any_q, any_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;

  // sweep
  logic [CNT_W-1:0] scan_cnt_q, scan_cnt_d;
  logic             p_vld_q, p_vld_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  slot_t            rd_q;

  logic [TABLE_DEPTH-1:0] slot_valid_q, slot_valid_d;
  slot_t                  slot_mem [TABLE_DEPTH];
  logic                   mem_we;

  // accumulators of one pass
  logic                    free_found_q, free_found_d;
  logic [IDX_W-1:0]        free_idx_q, free_idx_d;
  logic                    found_q, found_d;
  logic [IDX_W-1:0]        best_idx_q, best_idx_d;
  logic [REL_W-1:0]        best_rel_q, best_rel_d;
  logic [PAYLOAD_BITS-1:0] best_pay_q, best_pay_d;
  logic [CNT_W-1:0]        n_q, n_d;

  // search passes
  logic                    bounded_q, bounded_d;
  logic [REL_W-1:0]        bound_q, bound_d;
  logic [REL_W-1:0]        hold_rel_q, hold_rel_d;
  logic [PAYLOAD_BITS-1:0] hold_pay_q, hold_pay_d;
  logic [EMIT_W-1:0]       emit_cnt_q, emit_cnt_d;

  logic [CNT_W-1:0] entries_q, entries_d;
  logic [CNT_W-1:0] keys_q, keys_d;

  // result register
  logic                    res_vld_q, res_vld_d;
  status_e                 res_status_q, res_status_d;
  logic [REL_W-1:0]        res_rel_q, res_rel_d;
  logic [PAYLOAD_BITS-1:0] res_pay_q, res_pay_d;
  logic                    res_last_q, res_last_d;

  // compare unit
  logic slot_v, hit_key, rel_ok, below, match, take;

  assign slot_v  = slot_valid_q[rd_idx_q];
  assign hit_key = p_vld_q && slot_v && (rd_q.key == key_q);
  assign rel_ok  = any_q || (rd_q.rel == sel_q);
  assign below   = !bounded_q || (rd_q.rel < bound_q);
  assign match   = hit_key && rel_ok && below;
  assign take    = match && (!found_q || (rd_q.rel > best_rel_q));

  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    key_d        = key_q;
    sel_d        = sel_q;
    any_d        = any_q;
    pay_d        = pay_q;
    scan_cnt_d   = scan_cnt_q;
    p_vld_d      = 1'b0;
    rd_idx_d     = rd_idx_q;
    slot_valid_d = slot_valid_q;
    mem_we       = 1'b0;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_rel_d   = best_rel_q;
    best_pay_d   = best_pay_q;
    n_d          = n_q;
    bounded_d    = bounded_q;
    bound_d      = bound_q;
    hold_rel_d   = hold_rel_q;
    hold_pay_d   = hold_pay_q;
    emit_cnt_d   = emit_cnt_q;
    entries_d    = entries_q;
    keys_d       = keys_q;
    res_vld_d    = 1'b0;
    res_status_d = res_status_q;
    res_rel_d    = res_rel_q;
    res_pay_d    = res_pay_q;
    res_last_d   = res_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          // delete all without match_any is a plain delete one
          if (action_e'(action_i) == ACT_DEL_ALL && !match_any_i) begin
            act_d = ACT_DEL_ONE;
          end else begin
            act_d = action_e'(action_i);
          end
          key_d        = key_i;
          sel_d        = release_sel_i;
          any_d        = match_any_i || (action_e'(action_i) == ACT_INSERT);
          pay_d        = payload_i[PAYLOAD_BITS-1:0];
          scan_cnt_d   = '0;
          free_found_d = 1'b0;
          found_d      = 1'b0;
          n_d          = '0;
          bounded_d    = 1'b0;
          emit_cnt_d   = '0;
          state_d      = S_SCAN;
        end
      end

      S_SCAN: begin
        if (scan_cnt_q < CNT_W'(TABLE_DEPTH)) begin
          p_vld_d    = 1'b1;
          rd_idx_d   = scan_cnt_q[IDX_W-1:0];
          scan_cnt_d = scan_cnt_q + CNT_W'(1);
        end else begin
          state_d = S_FIN;
        end
        if (hit_key) begin
          n_d = n_q + CNT_W'(1);
          if (act_q == ACT_DEL_ALL) begin
            slot_valid_d[rd_idx_q] = 1'b0;
          end
        end
        if (p_vld_q && !slot_v && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = rd_idx_q;
        end
        if (take) begin
          found_d    = 1'b1;
          best_idx_d = rd_idx_q;
          best_rel_d = rd_q.rel;
          best_pay_d = rd_q.pay;
        end
      end

      S_FIN: begin
        state_d    = S_IDLE;
        res_pay_d  = '0;
        res_rel_d  = '0;
        res_last_d = 1'b1;
        unique case (act_q)
          ACT_INSERT: begin
            res_vld_d = 1'b1;
            if (!free_found_q) begin
              res_status_d = ST_FULL;
            end else if (found_q && best_rel_q == REL_MAX) begin
              res_status_d = ST_OVERFLOW;
            end else begin
              res_status_d = ST_OK;
              res_rel_d    = found_q ? best_rel_q + REL_W'(1) : REL_W'(1);
              mem_we       = 1'b1;
              slot_valid_d[free_idx_q] = 1'b1;
              entries_d    = entries_q + CNT_W'(1);
              if (!found_q) begin
                keys_d = keys_q + CNT_W'(1);
              end
            end
          end
          ACT_DEL_ONE: begin
            res_vld_d = 1'b1;
            if (!found_q) begin
              res_status_d = ST_NOT_FOUND;
            end else begin
              res_status_d = ST_OK;
              res_rel_d    = best_rel_q;
              slot_valid_d[best_idx_q] = 1'b0;
              entries_d    = entries_q - CNT_W'(1);
              if (n_q == CNT_W'(1)) begin
                keys_d = keys_q - CNT_W'(1);
              end
            end
          end
          ACT_DEL_ALL: begin
            res_vld_d = 1'b1;
            if (n_q == '0) begin
              res_status_d = ST_NOT_FOUND;
            end else begin
              res_status_d = ST_OK;
              entries_d    = entries_q - n_q;
              keys_d       = keys_q - CNT_W'(1);
            end
          end
          ACT_SEARCH: begin
            res_status_d = ST_OK;
            if (!bounded_q) begin
              if (!found_q) begin
                res_vld_d    = 1'b1;
                res_status_d = ST_NO_MATCH;
              end else begin
                // newest match found, hold it and look for the next older one
                hold_rel_d = best_rel_q;
                hold_pay_d = best_pay_q;
                bounded_d  = 1'b1;
                bound_d    = best_rel_q;
                state_d    = S_SCAN;
              end
            end else begin
              res_vld_d = 1'b1;
              res_rel_d = hold_rel_q;
              res_pay_d = PAY_PORT_W'(hold_pay_q);
              if (found_q && (EMIT_W'(emit_cnt_q + EMIT_W'(1)) < EMIT_W'(RESULT_CAP))) begin
                res_last_d = 1'b0;
                hold_rel_d = best_rel_q;
                hold_pay_d = best_pay_q;
                bound_d    = best_rel_q;
                emit_cnt_d = emit_cnt_q + EMIT_W'(1);
                state_d    = S_SCAN;
              end
            end
            if (state_d == S_SCAN) begin
              scan_cnt_d   = '0;
              found_d      = 1'b0;
              free_found_d = 1'b0;
              n_d          = '0;
            end
          end
          default: ;
        endcase
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      p_vld_q      <= 1'b0;
      slot_valid_q <= '0;
      entries_q    <= '0;
      keys_q       <= '0;
      res_vld_q    <= 1'b0;
      scan_cnt_q   <= '0;
      free_found_q <= 1'b0;
      found_q      <= 1'b0;
      bounded_q    <= 1'b0;
      emit_cnt_q   <= '0;
      n_q          <= '0;
    end else begin
      state_q      <= state_d;
      p_vld_q      <= p_vld_d;
      slot_valid_q <= slot_valid_d;
      entries_q    <= entries_d;
      keys_q       <= keys_d;
      res_vld_q    <= res_vld_d;
      scan_cnt_q   <= scan_cnt_d;
      free_found_q <= free_found_d;
      found_q      <= found_d;
      bounded_q    <= bounded_d;
      emit_cnt_q   <= emit_cnt_d;
      n_q          <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    key_q        <= key_d;
    sel_q        <= sel_d;
    any_q        <= any_d;
    pay_q        <= pay_d;
    rd_idx_q     <= rd_idx_d;
    free_idx_q   <= free_idx_d;
    best_idx_q   <= best_idx_d;
    best_rel_q   <= best_rel_d;
    best_pay_q   <= best_pay_d;
    bound_q      <= bound_d;
    hold_rel_q   <= hold_rel_d;
    hold_pay_q   <= hold_pay_d;
    res_status_q <= res_status_d;
    res_rel_q    <= res_rel_d;
    res_pay_q    <= res_pay_d;
    res_last_q   <= res_last_d;
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[free_idx_q] <= '{key: key_q, rel: res_rel_d, pay: pay_q};
    end
    rd_q <= slot_mem[rd_idx_d];
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_vld_q;
  assign status_o       = res_status_q;
  assign out_key_o      = key_q;
  assign out_release_o  = res_rel_q;
  assign out_payload_o  = res_pay_q;
  assign entry_count_o  = COUNT_W'(entries_q);
  assign key_count_o    = COUNT_W'(keys_q);
  assign last_o         = res_last_q;

`ifndef SYNTHESIS
  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> $past(state_q == S_FIN))
    else $error("result strobe without a finishing step");

  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ($countones(slot_valid_q) == 32'(entries_q)))
    else $error("entry count differs from valid slots");

  a_keys_le_entries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (keys_q <= entries_q))
    else $error("more keys than entries");

  a_start_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == S_SCAN))
    else $error("accepted request did not start a sweep");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_last_q) |-> (state_d == S_IDLE || state_q == S_IDLE))
    else $error("final result while the sweep goes on");
`endif

endmodule

/* tb/versioned_key_table_tb.sv */
// versioned_key_table_tb: self-checking testbench for the versioned key table
// keeps its own copy of the table to predict each result; depends on vkt_pkg and the block
module versioned_key_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vkt_pkg::*;

  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES = 2 * (TABLE_DEPTH + 2);

  typedef struct {
    status_e           status;
    logic [KEY_W-1:0]  key;
    logic [REL_W-1:0]  rel;
    logic [63:0]       pay;
    logic [COUNT_W-1:0] entries;
    logic [COUNT_W-1:0] keys;
    logic              last;
  } table_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [ACTION_W-1:0] action_i = ACT_INSERT;
  logic signed [KEY_W-1:0] key_i = '0;
  logic [REL_W-1:0] release_sel_i = '0;
  logic match_any_i = 1'b0;
  logic [PAY_PORT_W-1:0] payload_i = '0;
  logic result_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic signed [KEY_W-1:0] out_key_o;
  logic [REL_W-1:0] out_release_o;
  logic [PAY_PORT_W-1:0] out_payload_o;
  logic [COUNT_W-1:0] entry_count_o;
  logic [COUNT_W-1:0] key_count_o;
  logic last_o;

  // predicted table contents
  logic              held_valid [TABLE_DEPTH];
  logic [KEY_W-1:0]  held_key   [TABLE_DEPTH];
  int unsigned       held_rel   [TABLE_DEPTH];
  logic [63:0]       held_pay   [TABLE_DEPTH];
  int unsigned       held_entries;
  int unsigned       held_keys;

  table_result_t pending_results[$];
  table_result_t head;

  int unsigned errors = 0;
  int unsigned requests_sent = 0;
  int unsigned results_checked = 0;
  int unsigned deepest_search = 0;
  int unsigned idle_max = 11;
  int unsigned stall_cycles = 0;

  always #5 clk_i = ~clk_i;

  versioned_key_table u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .key_i          (key_i),
    .release_sel_i  (release_sel_i),
    .match_any_i    (match_any_i),
    .payload_i      (payload_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .out_key_o      (out_key_o),
    .out_release_o  (out_release_o),
    .out_payload_o  (out_payload_o),
    .entry_count_o  (entry_count_o),
    .key_count_o    (key_count_o),
    .last_o         (last_o)
  );

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    if (errors <= 30) begin
      $display("mismatch %0d at %0t ns: %s got %h want %h", errors, $realtime, what, got,
               want);
    end
  endtask

  function automatic table_result_t make_result(status_e st, logic [KEY_W-1:0] k,
                                                logic [REL_W-1:0] r, logic [63:0] p,
                                                logic last);
    table_result_t res;
    res.status  = st;
    res.key     = k;
    res.rel     = r;
    res.pay     = p;
    res.entries = held_entries[COUNT_W-1:0];
    res.keys    = held_keys[COUNT_W-1:0];
    res.last    = last;
    return res;
  endfunction

  function automatic int unsigned versions_held(logic [KEY_W-1:0] k, output int unsigned top);
    int unsigned n;
    n = 0;
    top = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (held_valid[i] && held_key[i] == k) begin
        n++;
        if (held_rel[i] > top) top = held_rel[i];
      end
    end
    return n;
  endfunction

  // update the predicted table for one accepted request and queue its results
  task automatic predict_table_op(input action_e act, input logic [KEY_W-1:0] k,
                                  input logic [REL_W-1:0] rel_sel, input logic any,
                                  input logic [63:0] pay);
    int unsigned n;
    int unsigned top;
    int unsigned dummy;
    int free_slot;
    int target;
    int pos;
    int hits[$];
    free_slot = -1;
    target = -1;
    if (act == ACT_DEL_ALL && !any) act = ACT_DEL_ONE;
    case (act)
      ACT_INSERT: begin
        n = versions_held(k, top);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (!held_valid[i] && free_slot < 0) free_slot = i;
        end
        if (free_slot < 0) begin
          pending_results.push_back(make_result(ST_FULL, k, '0, '0, 1'b1));
        end else if (n > 0 && top >= REL_MAX) begin
          pending_results.push_back(make_result(ST_OVERFLOW, k, '0, '0, 1'b1));
        end else begin
          held_valid[free_slot] = 1'b1;
          held_key[free_slot] = k;
          held_rel[free_slot] = (n > 0) ? top + 1 : 1;
          held_pay[free_slot] = pay;
          held_entries++;
          if (n == 0) held_keys++;
          pending_results.push_back(make_result(ST_OK, k, held_rel[free_slot][REL_W-1:0],
                                                '0, 1'b1));
        end
      end
      ACT_DEL_ONE: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (held_valid[i] && held_key[i] == k) begin
            if (any) begin
              if (target < 0 || held_rel[i] > held_rel[target]) target = i;
            end else if (held_rel[i] == rel_sel && target < 0) begin
              target = i;
            end
          end
        end
        if (target < 0) begin
          pending_results.push_back(make_result(ST_NOT_FOUND, k, '0, '0, 1'b1));
        end else begin
          held_valid[target] = 1'b0;
          held_entries--;
          if (versions_held(k, dummy) == 0) held_keys--;
          pending_results.push_back(make_result(ST_OK, k, held_rel[target][REL_W-1:0],
                                                '0, 1'b1));
        end
      end
      ACT_DEL_ALL: begin
        n = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (held_valid[i] && held_key[i] == k) begin
            held_valid[i] = 1'b0;
            n++;
          end
        end
        if (n == 0) begin
          pending_results.push_back(make_result(ST_NOT_FOUND, k, '0, '0, 1'b1));
        end else begin
          held_entries -= n;
          held_keys--;
          pending_results.push_back(make_result(ST_OK, k, '0, '0, 1'b1));
        end
      end
      default: begin
        // newest first: releases of one key are unique
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (held_valid[i] && held_key[i] == k && (any || held_rel[i] == rel_sel)) begin
            pos = 0;
            while (pos < hits.size() && held_rel[hits[pos]] > held_rel[i]) pos++;
            hits.insert(pos, i);
          end
        end
        if (hits.size() == 0) begin
          pending_results.push_back(make_result(ST_NO_MATCH, k, '0, '0, 1'b1));
        end else begin
          while (hits.size() > RESULT_CAP) void'(hits.pop_back());
          if (hits.size() > deepest_search) deepest_search = hits.size();
          foreach (hits[j]) begin
            pending_results.push_back(make_result(ST_OK, held_key[hits[j]],
                                                  held_rel[hits[j]][REL_W-1:0],
                                                  held_pay[hits[j]],
                                                  j == hits.size() - 1));
          end
        end
      end
    endcase
  endtask

  // present one request after a random gap and hold it until the block takes it
  task automatic send_request(input action_e act, input logic [KEY_W-1:0] k,
                              input logic [REL_W-1:0] rel_sel, input logic any,
                              input logic [63:0] pay);
    int unsigned gap;
    gap = $urandom_range(0, idle_max);
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start <= 1'b1;
    action_i <= act;
    key_i <= k;
    release_sel_i <= rel_sel;
    match_any_i <= any;
    payload_i <= pay;
    do @(posedge clk_i); while (busy);
    requests_sent++;
    predict_table_op(act, k, rel_sel, any, pay);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected, status", 64'(status_o), '0);
      end else begin
        head = pending_results.pop_front();
        if (status_o !== head.status)
          report_mismatch("status", 64'(status_o), 64'(head.status));
        if (out_key_o !== head.key)
          report_mismatch("out_key", 64'(unsigned'(out_key_o)), 64'(head.key));
        if (out_release_o !== head.rel)
          report_mismatch("out_release", 64'(out_release_o), 64'(head.rel));
        if (out_payload_o !== head.pay) report_mismatch("out_payload", out_payload_o, head.pay);
        if (entry_count_o !== head.entries)
          report_mismatch("entry_count", 64'(entry_count_o), 64'(head.entries));
        if (key_count_o !== head.keys)
          report_mismatch("key_count", 64'(key_count_o), 64'(head.keys));
        if (last_o !== head.last) report_mismatch("last", 64'(last_o), 64'(head.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no request or result taken for %0d cycles", STALL_LIMIT);
      $display("versioned_key_table_tb: done, errors");
      $finish;
    end
  end

  // extremes of keys and payloads, every operation, the not-found and no-match paths
  task automatic test_directed_ops();
    send_request(ACT_SEARCH, 32'h0, 16'h0, 1'b1, 64'h0);
    send_request(ACT_DEL_ONE, 32'h0, 16'h0, 1'b1, 64'h0);
    send_request(ACT_DEL_ALL, 32'h0, 16'h0, 1'b1, 64'h0);
    send_request(ACT_INSERT, 32'h8000_0000, 16'hFFFF, 1'b1, 64'h0);
    send_request(ACT_INSERT, 32'h7FFF_FFFF, 16'h0, 1'b0, {64{1'b1}});
    send_request(ACT_INSERT, 32'hFFFF_FFFF, 16'h0, 1'b0, 64'hA5A5_A5A5_A5A5_A5A5);
    send_request(ACT_INSERT, 32'h0, 16'h0, 1'b0, 64'h5A5A_5A5A_5A5A_5A5A);
    send_request(ACT_INSERT, 32'h8000_0000, 16'h0, 1'b0, 64'h0123_4567_89AB_CDEF);
    send_request(ACT_INSERT, 32'h8000_0000, 16'h0, 1'b0, 64'hFEDC_BA98_7654_3210);
    send_request(ACT_SEARCH, 32'h8000_0000, 16'h0, 1'b1, 64'h0);
    send_request(ACT_SEARCH, 32'h8000_0000, 16'h2, 1'b0, 64'h0);
    // release zero never matches without match_any
    send_request(ACT_SEARCH, 32'h8000_0000, 16'h0, 1'b0, 64'h0);
    send_request(ACT_SEARCH, 32'h8000_0000, 16'hFFFF, 1'b0, 64'h0);
    send_request(ACT_DEL_ONE, 32'h8000_0000, 16'h0, 1'b0, 64'h0);
    send_request(ACT_DEL_ONE, 32'h8000_0000, 16'h2, 1'b0, 64'h0);
    send_request(ACT_DEL_ONE, 32'h8000_0000, 16'h0, 1'b1, 64'h0);
    send_request(ACT_INSERT, 32'h8000_0000, 16'h0, 1'b0, {$urandom, $urandom});
    // delete all without match_any acts on one release only
    send_request(ACT_DEL_ALL, 32'h8000_0000, 16'h1, 1'b0, 64'h0);
    send_request(ACT_DEL_ALL, 32'h8000_0000, 16'h7, 1'b0, 64'h0);
    send_request(ACT_DEL_ALL, 32'h8000_0000, 16'h0, 1'b1, 64'h0);
    send_request(ACT_DEL_ALL, 32'h7FFF_FFFF, 16'h0, 1'b1, 64'h0);
    send_request(ACT_DEL_ALL, 32'hFFFF_FFFF, 16'h0, 1'b1, 64'h0);
    send_request(ACT_DEL_ONE, 32'h0, 16'h0, 1'b1, 64'h0);
    send_request(ACT_SEARCH, 32'h0, 16'h0, 1'b1, 64'h0);
  endtask

  // one key fills every slot; the widest search and the full check
  task automatic test_full_table();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      send_request(ACT_INSERT, 32'h0000_0042, 16'h0, 1'b0, {$urandom, $urandom});
    end
    send_request(ACT_INSERT, 32'h0000_0042, 16'h0, 1'b0, {$urandom, $urandom});
    send_request(ACT_INSERT, 32'h1234_5678, 16'h0, 1'b0, {$urandom, $urandom});
    send_request(ACT_SEARCH, 32'h0000_0042, 16'h0, 1'b1, 64'h0);
    send_request(ACT_SEARCH, 32'h0000_0042, 16'h11, 1'b0, 64'h0);
    send_request(ACT_DEL_ONE, 32'h0000_0042, 16'h20, 1'b0, 64'h0);
    send_request(ACT_DEL_ONE, 32'h0000_0042, 16'h0, 1'b1, 64'h0);
    send_request(ACT_INSERT, 32'h1234_5678, 16'h0, 1'b0, {$urandom, $urandom});
    send_request(ACT_SEARCH, 32'h0000_0042, 16'h0, 1'b1, 64'h0);
    send_request(ACT_DEL_ALL, 32'h0000_0042, 16'h0, 1'b1, 64'h0);
    send_request(ACT_DEL_ALL, 32'h1234_5678, 16'h0, 1'b1, 64'h0);
  endtask

  // walk one key up past deleted releases, keeping only its newest version
  task automatic test_release_climb();
    logic [KEY_W-1:0] hot_key;
    hot_key = 32'h5A5A_0001;
    send_request(ACT_INSERT, hot_key, 16'h0, 1'b0, {$urandom, $urandom});
    for (int r = 1; r < 16; r++) begin
      send_request(ACT_INSERT, hot_key, 16'h0, 1'b0, {$urandom, $urandom});
      send_request(ACT_DEL_ONE, hot_key, 16'(r), 1'b0, 64'h0);
    end
    send_request(ACT_SEARCH, hot_key, 16'h0, 1'b1, 64'h0);
    send_request(ACT_SEARCH, hot_key, 16'h3, 1'b0, 64'h0);
    for (int i = 1; i < TABLE_DEPTH; i++) begin
      send_request(ACT_INSERT, 32'h0000_0077, 16'h0, 1'b0, {$urandom, $urandom});
    end
    // full with the key already present
    send_request(ACT_INSERT, hot_key, 16'h0, 1'b0, {$urandom, $urandom});
    send_request(ACT_DEL_ONE, 32'h0000_0077, 16'h0, 1'b1, 64'h0);
    send_request(ACT_INSERT, hot_key, 16'h0, 1'b0, {$urandom, $urandom});
    send_request(ACT_DEL_ALL, hot_key, 16'h0, 1'b1, 64'h0);
    send_request(ACT_DEL_ALL, 32'h0000_0077, 16'h0, 1'b1, 64'h0);
  endtask

  // mostly a small pool of keys so versions pile up, with random keys and releases mixed in
  task automatic test_random_mix(input int unsigned count);
    int unsigned pick;
    int unsigned insert_weight;
    logic [KEY_W-1:0] k;
    logic [REL_W-1:0] rel_sel;
    action_e act;
    int unsigned held[$];
    for (int n = 0; n < count; n++) begin
      if (n % 25 == 0) idle_max = ($urandom_range(0, 2) == 0) ? 0 : 11;
      if ($urandom_range(0, 99) < 85) begin
        case ($urandom_range(0, 5))
          0: k = 32'h8000_0000;
          1: k = 32'h7FFF_FFFF;
          2: k = 32'h0000_0000;
          3: k = 32'hFFFF_FFFF;
          4: k = 32'h0000_1234;
          default: k = 32'hDEAD_BEEF;
        endcase
      end else begin
        k = $urandom;
      end
      insert_weight = (held_entries < 8) ? 55 : (held_entries >= 28) ? 15 : 35;
      pick = $urandom_range(0, 99);
      if (pick < insert_weight) act = ACT_INSERT;
      else if (pick < insert_weight + 20) act = ACT_DEL_ONE;
      else if (pick < insert_weight + 28) act = ACT_DEL_ALL;
      else act = ACT_SEARCH;
      held.delete();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (held_valid[i] && held_key[i] == k) held.push_back(held_rel[i]);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70 && held.size() > 0)
        rel_sel = REL_W'(held[$urandom_range(0, held.size() - 1)]);
      else if (pick < 85) rel_sel = REL_W'($urandom_range(0, 3));
      else rel_sel = REL_W'($urandom);
      send_request(act, k, rel_sel, $urandom_range(0, 2) == 0, {$urandom, $urandom});
    end
    idle_max = 11;
  endtask

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      held_valid[i] = 1'b0;
      held_key[i] = '0;
      held_rel[i] = 0;
      held_pay[i] = '0;
    end
    held_entries = 0;
    held_keys = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_ops();
    test_full_table();
    test_release_climb();
    test_random_mix(225);

    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      report_mismatch("results never delivered", 64'(pending_results.size()), '0);
    end

    $display("ran %0d requests and checked %0d results", requests_sent, results_checked);
    $display("covered full table, releases climbing past deleted versions and searches up to %0d matches",
             deepest_search);
    if (errors == 0) begin
      $display("versioned_key_table_tb: done, clean");
    end else begin
      $display("versioned_key_table_tb: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
src/vkt_pkg.sv
src/versioned_key_table.sv
tb/versioned_key_table_tb.sv
